[rtl/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)

`define ASSERT_NEVER(lbl, clk, rst, expr)

`endif

`endif

[rtl/tbdslp_pkg.sv]
`timescale 1ns / 1ps

package tbdslp_pkg;

   localparam int CSR_INDEX_W = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_START_TIME      = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_COOLDOWN_TIME   = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LONG_PRESS_TIME = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DEBOUNCE_COUNT  = 8'd3;

   localparam logic [31:0] START_TIME_RST      = 32'd0;
   localparam logic [15:0] COOLDOWN_TIME_RST   = 16'd2000;
   localparam logic [15:0] LONG_PRESS_TIME_RST = 16'd2000;
   localparam logic [3:0]  DEBOUNCE_COUNT_RST  = 4'd5;

   typedef struct packed {
      logic [31:0] start_time;
      logic [15:0] cooldown_time;
      logic [15:0] long_press_time;
      logic [3:0]  debounce_count;
   } cfg_type;

   typedef struct packed {
      logic [31:0] now_time;
      logic        boot_level;
      logic        power_level;
      logic        race_screen;
   } item_type;

   typedef struct packed {
      logic short_event;
      logic long_event;
      logic zero_event;
   } event_type;

endpackage

[rtl/tbdslp_core.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tbdslp_core
   import tbdslp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      step,
   input  item_type  item,
   input  cfg_type   cfg,
   output event_type events
);

   typedef enum logic [1:0] {
      MODE_IDLE,
      MODE_DEBOUNCE,
      MODE_PRESSED,
      MODE_LONG
   } boot_mode_type;

   logic          cooldown_over_ff, cooldown_over_in;
   logic          boot_baseline_ff, boot_baseline_in;
   boot_mode_type boot_mode_ff, boot_mode_in;
   logic [3:0]    boot_counter_ff, boot_counter_in;
   logic [31:0]   press_time_ff, press_time_in;
   logic [3:0]    power_counter_ff, power_counter_in;
   logic          power_stable_ff, power_stable_in;
   logic          power_fired_ff, power_fired_in;

   logic [31:0] since_start;
   logic [31:0] held_time;
   logic        in_cooldown;
   logic        baseline_now;
   logic [3:0]  boot_inc;
   logic [3:0]  power_inc;
   logic        power_fire;

   assign since_start = item.now_time - cfg.start_time;
   assign held_time   = item.now_time - press_time_ff;
   assign in_cooldown = !cooldown_over_ff && (since_start < {16'd0, cfg.cooldown_time});
   // first tick past the cooldown latches the held boot level as baseline
   assign baseline_now = cooldown_over_ff ? boot_baseline_ff : item.boot_level;
   assign boot_inc  = boot_counter_ff + 4'd1;
   assign power_inc = power_counter_ff + 4'd1;

   always_comb begin
      cooldown_over_in = cooldown_over_ff;
      boot_baseline_in = boot_baseline_ff;
      boot_mode_in     = boot_mode_ff;
      boot_counter_in  = boot_counter_ff;
      press_time_in    = press_time_ff;
      power_counter_in = power_counter_ff;
      power_stable_in  = power_stable_ff;
      power_fired_in   = power_fired_ff;
      power_fire       = 1'b0;
      events           = '0;

      if (in_cooldown) begin
         power_counter_in = 4'd0;
         power_stable_in  = 1'b0;
         power_fired_in   = 1'b0;
         boot_mode_in     = MODE_IDLE;
      end else begin
         cooldown_over_in = 1'b1;
         boot_baseline_in = baseline_now;

         if (baseline_now) begin
            if (!item.boot_level) begin
               boot_baseline_in = 1'b0;
               boot_mode_in     = MODE_IDLE;
            end
         end else begin
            case (boot_mode_ff)
               MODE_IDLE: begin
                  if (item.boot_level) begin
                     boot_counter_in = 4'd0;
                     boot_mode_in    = MODE_DEBOUNCE;
                  end
               end
               MODE_DEBOUNCE: begin
                  if (item.boot_level) begin
                     boot_counter_in = boot_inc;
                     if (boot_inc >= cfg.debounce_count) begin
                        press_time_in = item.now_time;
                        boot_mode_in  = MODE_PRESSED;
                     end
                  end else begin
                     boot_counter_in = 4'd0;
                     boot_mode_in    = MODE_IDLE;
                  end
               end
               MODE_PRESSED: begin
                  if (held_time >= {16'd0, cfg.long_press_time}) begin
                     boot_mode_in      = MODE_LONG;
                     events.long_event = 1'b1;
                  end else if (!item.boot_level) begin
                     events.short_event = 1'b1;
                     boot_mode_in       = MODE_IDLE;
                     press_time_in      = 32'd0;
                  end
               end
               MODE_LONG: begin
                  if (!item.boot_level) begin
                     boot_mode_in = MODE_IDLE;
                  end
               end
               default: begin
                  boot_mode_in = MODE_IDLE;
               end
            endcase
         end

         // counter saturates at the debounce count; stable and fired move together
         if (item.power_level) begin
            if (power_counter_ff < cfg.debounce_count) begin
               power_counter_in = power_inc;
               if ((power_inc >= cfg.debounce_count) && !power_stable_ff) begin
                  power_stable_in = 1'b1;
                  if (!power_fired_ff) begin
                     power_fired_in = 1'b1;
                     power_fire     = 1'b1;
                  end
               end
            end
         end else begin
            power_counter_in = 4'd0;
            power_stable_in  = 1'b0;
            power_fired_in   = 1'b0;
         end

         events.zero_event = power_fire && item.race_screen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooldown_over_ff <= 1'b0;
         boot_baseline_ff <= 1'b0;
         boot_mode_ff     <= MODE_IDLE;
         boot_counter_ff  <= 4'd0;
         press_time_ff    <= 32'd0;
         power_counter_ff <= 4'd0;
         power_stable_ff  <= 1'b0;
         power_fired_ff   <= 1'b0;
      end else if (step) begin
         cooldown_over_ff <= cooldown_over_in;
         boot_baseline_ff <= boot_baseline_in;
         boot_mode_ff     <= boot_mode_in;
         boot_counter_ff  <= boot_counter_in;
         press_time_ff    <= press_time_in;
         power_counter_ff <= power_counter_in;
         power_stable_ff  <= power_stable_in;
         power_fired_ff   <= power_fired_in;
      end
   end

   `ASSERT_NEVER(a_short_and_long, clock, reset, step && events.short_event && events.long_event)
   `ASSERT_CLK(a_idle_in_cooldown, clock, reset, !cooldown_over_ff |-> boot_mode_ff == MODE_IDLE)
   `ASSERT_CLK(a_power_flags_agree, clock, reset, power_stable_ff == power_fired_ff)
   `ASSERT_CLK(a_long_enters_long, clock, reset, step && events.long_event |=> boot_mode_ff == MODE_LONG)

endmodule

[rtl/two_button_debounce_short_long_press.sv]
`timescale 1ns / 1ps

// Each accepted word passes through the request register and then the response register.
// Throughput: one word per cycle unless rsp_stall backs up into a full request register.
// Button state updates when a word moves from the request register to the response register.
// Reset (synchronous, active high) empties both registers, clears button state and
// loads the CSR defaults; no clearing pass, words are taken right after reset.
module two_button_debounce_short_long_press
   import tbdslp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [31:0]            req_now_time,
   input  logic                   req_boot_level,
   input  logic                   req_power_level,
   input  logic                   req_race_screen,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_short_event,
   output logic                   rsp_long_event,
   output logic                   rsp_zero_event,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type   cfg_ff;
   item_type  item_ff;
   logic      item_valid_ff, item_valid_in;
   logic      rsp_valid_ff, rsp_valid_in;
   event_type rsp_events_ff;
   event_type events;
   logic      out_free;
   logic      advance;
   logic      req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = item_valid_ff && out_free;
   assign req_stall = item_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_time      <= START_TIME_RST;
         cfg_ff.cooldown_time   <= COOLDOWN_TIME_RST;
         cfg_ff.long_press_time <= LONG_PRESS_TIME_RST;
         cfg_ff.debounce_count  <= DEBOUNCE_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_START_TIME:      cfg_ff.start_time      <= csr_data;
            REG_COOLDOWN_TIME:   cfg_ff.cooldown_time   <= csr_data[15:0];
            REG_LONG_PRESS_TIME: cfg_ff.long_press_time <= csr_data[15:0];
            REG_DEBOUNCE_COUNT:  cfg_ff.debounce_count  <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.now_time    <= req_now_time;
         item_ff.boot_level  <= req_boot_level;
         item_ff.power_level <= req_power_level;
         item_ff.race_screen <= req_race_screen;
      end
      if (advance) begin
         rsp_events_ff <= events;
      end
   end

   tbdslp_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .events (events)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_short_event = rsp_events_ff.short_event;
   assign rsp_long_event  = rsp_events_ff.long_event;
   assign rsp_zero_event  = rsp_events_ff.zero_event;

endmodule
